FILE: rtl/core/chc_pkg.sv
package chc_pkg;

	localparam int LEN_W = 6;
	localparam int CODE_W = 32;

	localparam logic [1:0] FN_LOAD = 2'd0;
	localparam logic [1:0] FN_ENC  = 2'd1;
	localparam logic [1:0] FN_DEC  = 2'd2;

	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_CODE     = 3'd1;
	localparam logic [2:0] ST_DECODED  = 3'd2;
	localparam logic [2:0] ST_MORE     = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       symbol;
		logic [LEN_W-1:0] length;
		logic             bit_req;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
		logic [7:0]        out_symbol;
	} result_t;

	function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] n);
		logic [CODE_W-1:0] m;
		if (n >= LEN_W'(CODE_W)) begin
			m = '1;
		end else begin
			m = (CODE_W'(1) << n) - CODE_W'(1);
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/chc_front.sv
module chc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  chc_pkg::item_t in_item,
	output logic           busy,
	input  logic           pop,
	output logic           head_valid,
	output chc_pkg::item_t head
);

	chc_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;

	assign busy       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

FILE: rtl/core/chc_back.sv
module chc_back #(
	parameter int NUM_SYMBOLS  = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  chc_pkg::item_t   head,
	output logic             pop,
	output logic             res_valid,
	output chc_pkg::result_t res
);

	localparam int SW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int CW = $clog2(NUM_SYMBOLS + 1);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int DEPTH_L = MAX_CODE_LEN + 1;
	localparam int LEN_W = chc_pkg::LEN_W;
	localparam int CODE_W = chc_pkg::CODE_W;

	typedef enum logic [14:0] {
		S_IDLE    = 15'h0001,
		S_GO      = 15'h0002,
		S_CLR     = 15'h0004,
		S_CNT_RD  = 15'h0008,
		S_CNT_CNT = 15'h0010,
		S_CNT_WR  = 15'h0020,
		S_BASE_RD = 15'h0040,
		S_BASE_WR = 15'h0080,
		S_ASG_RD  = 15'h0100,
		S_ASG_NX  = 15'h0200,
		S_ASG_WR  = 15'h0400,
		S_ENC     = 15'h0800,
		S_DEC1    = 15'h1000,
		S_DEC2    = 15'h2000,
		S_DEC3    = 15'h4000
	} state_t;

	logic [LEN_W-1:0]  len_mem   [NUM_SYMBOLS];
	logic [CODE_W-1:0] code_mem  [NUM_SYMBOLS];
	logic [SW-1:0]     sort_mem  [NUM_SYMBOLS];
	logic [CW-1:0]     cnt_mem   [DEPTH_L];
	logic [CODE_W-1:0] fc_mem    [DEPTH_L];
	logic [CW-1:0]     fi_mem    [DEPTH_L];
	logic [CODE_W-1:0] nc_mem    [DEPTH_L];
	logic [CW-1:0]     np_mem    [DEPTH_L];
	logic [NUM_SYMBOLS-1:0] len_valid_q;

	state_t            state_q, state_d;
	chc_pkg::item_t    item_q;
	logic [SW-1:0]     sym_q;
	logic [LW-1:0]     lc_q;
	logic [CODE_W-1:0] code_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     prev_q;
	logic              stale_q;
	logic [CODE_W-1:0] pc_q;
	logic [LEN_W-1:0]  pl_q;
	logic [LEN_W-1:0]  dl_q;

	logic [LEN_W-1:0]  len_rd_q;
	logic              lv_rd_q;
	logic [CODE_W-1:0] code_rd_q;
	logic [SW-1:0]     sort_rd_q;
	logic [CW-1:0]     cnt_rd_q;
	logic [CODE_W-1:0] fc_rd_q;
	logic [CW-1:0]     fi_rd_q;
	logic [CODE_W-1:0] nc_rd_q;
	logic [CW-1:0]     np_rd_q;

	logic              res_valid_q;
	chc_pkg::result_t  res_q;

	logic [LEN_W-1:0]  len_eff;
	logic [LW-1:0]     len_idx;
	logic              sym_last;
	logic              lc_last;
	logic              in_range;
	logic [LEN_W-1:0]  sat_len;
	logic [CODE_W-1:0] npc;
	logic [LEN_W-1:0]  npl;
	logic [LEN_W-1:0]  dl;
	logic [CODE_W-1:0] off;
	logic              match;
	logic [CODE_W-1:0] base_next;
	logic              res_fire;

	assign len_eff   = lv_rd_q ? len_rd_q : '0;
	assign len_idx   = len_rd_q[LW-1:0];
	assign sym_last  = (sym_q == SW'(NUM_SYMBOLS - 1));
	assign lc_last   = (lc_q == LW'(MAX_CODE_LEN));
	assign in_range  = ({1'b0, item_q.symbol} < 9'(NUM_SYMBOLS));
	assign sat_len   = (item_q.length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
	                                                          : item_q.length;
	assign npc       = {pc_q[CODE_W-2:0], item_q.bit_req};
	assign npl       = pl_q + LEN_W'(1);
	assign dl        = (npl > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : npl;
	assign off       = pc_q - fc_rd_q;
	assign match     = (off < CODE_W'(cnt_rd_q));
	assign base_next = (code_q + CODE_W'(prev_q)) << 1;
	assign res_fire  = ((state_q == S_GO) && (item_q.func == chc_pkg::FN_LOAD)) ||
	                   (state_q == S_ENC) || ((state_q == S_DEC1) && !match) ||
	                   (state_q == S_DEC2);

	assign pop       = (state_q == S_IDLE) && head_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					state_d = S_GO;
				end
			end
			S_GO: begin
				case (item_q.func)
					chc_pkg::FN_ENC: state_d = stale_q ? S_CLR : S_ENC;
					chc_pkg::FN_DEC: state_d = stale_q ? S_CLR : S_DEC1;
					default:         state_d = S_IDLE;
				endcase
			end
			S_CLR:     state_d = lc_last ? S_CNT_RD : S_CLR;
			S_CNT_RD:  state_d = S_CNT_CNT;
			S_CNT_CNT: state_d = S_CNT_WR;
			S_CNT_WR:  state_d = sym_last ? S_BASE_RD : S_CNT_RD;
			S_BASE_RD: state_d = S_BASE_WR;
			S_BASE_WR: state_d = lc_last ? S_ASG_RD : S_BASE_RD;
			S_ASG_RD:  state_d = S_ASG_NX;
			S_ASG_NX:  state_d = S_ASG_WR;
			S_ASG_WR:  state_d = sym_last ? S_DEC3 : S_ASG_RD;
			S_DEC3:    state_d = S_GO;
			S_ENC:     state_d = S_IDLE;
			S_DEC1:    state_d = match ? S_DEC2 : S_IDLE;
			S_DEC2:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stale_q     <= 1'b1;
			pc_q        <= '0;
			pl_q        <= '0;
			len_valid_q <= '0;
			res_valid_q <= 1'b0;
			sym_q       <= '0;
			lc_q        <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_fire;
			case (state_q)
				S_GO: begin
					if (item_q.func == chc_pkg::FN_LOAD) begin
						if (in_range) begin
							len_valid_q[item_q.symbol[SW-1:0]] <= 1'b1;
						end
						stale_q <= 1'b1;
						pc_q    <= '0;
						pl_q    <= '0;
					end else if (item_q.func == chc_pkg::FN_DEC && !stale_q) begin
						pc_q <= npc;
						pl_q <= npl;
					end
					lc_q <= '0;
				end
				S_CLR: begin
					lc_q  <= lc_last ? LW'(1) : lc_q + LW'(1);
					sym_q <= '0;
				end
				S_CNT_WR: begin
					sym_q <= sym_last ? '0 : sym_q + SW'(1);
				end
				S_BASE_WR: begin
					lc_q <= lc_q + LW'(1);
				end
				S_ASG_WR: begin
					sym_q <= sym_q + SW'(1);
					if (sym_last) begin
						stale_q <= 1'b0;
					end
				end
				S_DEC1: begin
					if (!match && pl_q >= LEN_W'(MAX_CODE_LEN)) begin
						pc_q <= '0;
						pl_q <= '0;
					end
				end
				S_DEC2: begin
					pc_q <= '0;
					pl_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath, results and memories
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		case (state_q)
			S_GO: begin
				res_q <= '{status: chc_pkg::ST_LOADED, code_bits: '0, code_len: '0,
				           out_symbol: '0};
				if (item_q.func == chc_pkg::FN_LOAD && in_range) begin
					len_mem[item_q.symbol[SW-1:0]] <= sat_len;
				end
				if (item_q.func == chc_pkg::FN_ENC) begin
					len_rd_q  <= len_mem[item_q.symbol[SW-1:0]];
					lv_rd_q   <= len_valid_q[item_q.symbol[SW-1:0]];
					code_rd_q <= code_mem[item_q.symbol[SW-1:0]];
				end
				if (item_q.func == chc_pkg::FN_DEC) begin
					dl_q     <= dl;
					fc_rd_q  <= fc_mem[dl[LW-1:0]];
					cnt_rd_q <= cnt_mem[dl[LW-1:0]];
					fi_rd_q  <= fi_mem[dl[LW-1:0]];
				end
			end
			S_CLR: begin
				cnt_mem[lc_q] <= '0;
				fc_mem[lc_q]  <= '0;
				fi_mem[lc_q]  <= '0;
				code_q <= '0;
				idx_q  <= '0;
				prev_q <= '0;
			end
			S_CNT_RD, S_ASG_RD: begin
				len_rd_q <= len_mem[sym_q];
				lv_rd_q  <= len_valid_q[sym_q];
			end
			S_CNT_CNT: begin
				cnt_rd_q <= cnt_mem[len_idx];
			end
			S_CNT_WR: begin
				if (len_eff != '0) begin
					cnt_mem[len_idx] <= cnt_rd_q + CW'(1);
				end
			end
			S_BASE_RD: begin
				cnt_rd_q <= cnt_mem[lc_q];
			end
			S_BASE_WR: begin
				fc_mem[lc_q] <= base_next;
				fi_mem[lc_q] <= idx_q;
				nc_mem[lc_q] <= base_next;
				np_mem[lc_q] <= idx_q;
				code_q <= base_next;
				idx_q  <= idx_q + cnt_rd_q;
				prev_q <= cnt_rd_q;
			end
			S_ASG_NX: begin
				nc_rd_q <= nc_mem[len_idx];
				np_rd_q <= np_mem[len_idx];
			end
			S_ASG_WR: begin
				if (len_eff != '0) begin
					sort_mem[np_rd_q[SW-1:0]] <= sym_q;
					code_mem[sym_q]  <= nc_rd_q;
					nc_mem[len_idx]  <= nc_rd_q + CODE_W'(1);
					np_mem[len_idx]  <= np_rd_q + CW'(1);
				end
			end
			S_ENC: begin
				if (in_range && len_eff != '0) begin
					res_q <= '{status: chc_pkg::ST_CODE,
					           code_bits: code_rd_q & chc_pkg::low_mask(len_eff),
					           code_len: len_eff, out_symbol: '0};
				end else begin
					res_q <= '{status: chc_pkg::ST_UNKNOWN, code_bits: '0, code_len: '0,
					           out_symbol: '0};
				end
			end
			S_DEC1: begin
				if (match) begin
					sort_rd_q <= sort_mem[fi_rd_q[SW-1:0] + off[SW-1:0]];
				end else if (pl_q >= LEN_W'(MAX_CODE_LEN)) begin
					res_q <= '{status: chc_pkg::ST_OVERFLOW, code_bits: '0, code_len: '0,
					           out_symbol: '0};
				end else begin
					res_q <= '{status: chc_pkg::ST_MORE, code_bits: pc_q, code_len: pl_q,
					           out_symbol: '0};
				end
			end
			S_DEC2: begin
				res_q <= '{status: chc_pkg::ST_DECODED, code_bits: pc_q, code_len: dl_q,
				           out_symbol: 8'(sort_rd_q)};
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/canonical_huffman_codec.sv
// Canonical Huffman codec. Items enter when start is high and busy is low; a
// two-item queue sits in front of the execution engine. The first encode
// or decode after any load first rebuilds the code tables, a walk over
// every symbol and every code length. Each result appears for exactly one
// cycle with strobe high; the receiver cannot stall it and must take it then.
module canonical_huffman_codec #(
	parameter int NUM_SYMBOLS  = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  symbol,
	input  logic [5:0]  length,
	input  logic        bit_req,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [31:0] code_bits,
	output logic [5:0]  code_len,
	output logic [7:0]  out_symbol
);

	chc_pkg::item_t   in_item;
	chc_pkg::item_t   head;
	chc_pkg::result_t res;
	logic             head_valid;
	logic             pop;

	assign in_item = '{func: func, symbol: symbol, length: length, bit_req: bit_req};

	chc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (start && !busy),
		.in_item    (in_item),
		.busy       (busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	chc_back #(
		.NUM_SYMBOLS  (NUM_SYMBOLS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (strobe),
		.res        (res)
	);

	assign status     = res.status;
	assign code_bits  = res.code_bits;
	assign code_len   = res.code_len;
	assign out_symbol = res.out_symbol;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int N_SYM = 256;
	localparam int MAX_LEN = 32;
	localparam logic [1:0] FN_NONE = 2'd3;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] func = chc_pkg::FN_LOAD;
	logic [7:0] symbol = '0;
	logic [5:0] length = '0;
	logic bit_req = 1'b0;
	logic busy, strobe;
	logic [2:0] status;
	logic [31:0] code_bits;
	logic [5:0] code_len;
	logic [7:0] out_symbol;

	canonical_huffman_codec DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .symbol(symbol), .length(length), .bit_req(bit_req),
		.strobe(strobe), .status(status), .code_bits(code_bits),
		.code_len(code_len), .out_symbol(out_symbol)
	);

	always #5 clk = ~clk;

	// codec model
	logic [5:0]  len_tab [N_SYM];
	logic [31:0] code_tab [N_SYM];
	logic [31:0] cnt_at [MAX_LEN+1];
	logic [31:0] first_code [MAX_LEN+1];
	logic [31:0] first_idx [MAX_LEN+1];
	logic [7:0]  sym_by_rank [N_SYM];
	logic        stale;
	logic [31:0] acc_code;
	logic [31:0] acc_len;

	chc_pkg::result_t pending_results[$];
	bit failed = 0;
	int idle_cycles = 0;

	function automatic void rebuild_codes();
		logic [31:0] nc [MAX_LEN+1];
		logic [31:0] np [MAX_LEN+1];
		logic [31:0] c, idx;
		int l;
		for (int i = 0; i <= MAX_LEN; i++) cnt_at[i] = 0;
		for (int s = 0; s < N_SYM; s++)
			if (len_tab[s] != 0) cnt_at[len_tab[s]]++;
		c = 0;
		idx = 0;
		first_code[0] = 0;
		first_idx[0] = 0;
		for (l = 1; l <= MAX_LEN; l++) begin
			c = (c + cnt_at[l-1]) << 1;
			first_code[l] = c;
			first_idx[l] = idx;
			nc[l] = c;
			np[l] = idx;
			idx += cnt_at[l];
		end
		for (int s = 0; s < N_SYM; s++) begin
			l = len_tab[s];
			if (l != 0) begin
				sym_by_rank[np[l][7:0]] = s[7:0];
				code_tab[s] = nc[l];
				np[l]++;
				nc[l]++;
			end
		end
		stale = 0;
	endfunction

	function automatic void predict(input chc_pkg::item_t it);
		chc_pkg::result_t r;
		logic [31:0] l, off;
		r = '0;
		case (it.func)
			chc_pkg::FN_LOAD: begin
				len_tab[it.symbol] = (it.length > MAX_LEN) ? 6'(MAX_LEN) : it.length;
				stale = 1;
				acc_code = 0;
				acc_len = 0;
				r.status = chc_pkg::ST_LOADED;
			end
			chc_pkg::FN_ENC: begin
				if (stale) rebuild_codes();
				if (len_tab[it.symbol] != 0) begin
					r.code_len = len_tab[it.symbol];
					r.code_bits = code_tab[it.symbol] & chc_pkg::low_mask(r.code_len);
					r.status = chc_pkg::ST_CODE;
				end else begin
					r.status = chc_pkg::ST_UNKNOWN;
				end
			end
			chc_pkg::FN_DEC: begin
				if (stale) rebuild_codes();
				acc_code = (acc_code << 1) | it.bit_req;
				acc_len++;
				l = (acc_len > MAX_LEN) ? MAX_LEN : acc_len;
				off = acc_code - first_code[l];
				if (off < cnt_at[l]) begin
					r.out_symbol = sym_by_rank[8'(first_idx[l] + off)];
					r.code_bits = acc_code;
					r.code_len = 6'(l);
					r.status = chc_pkg::ST_DECODED;
					acc_code = 0;
					acc_len = 0;
				end else if (acc_len >= MAX_LEN) begin
					r.status = chc_pkg::ST_OVERFLOW;
					acc_code = 0;
					acc_len = 0;
				end else begin
					r.status = chc_pkg::ST_MORE;
					r.code_bits = acc_code;
					r.code_len = 6'(acc_len);
				end
			end
			default: return;
		endcase
		pending_results.push_back(r);
	endfunction

	always @(posedge clk) begin
		chc_pkg::result_t e;
		if (strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result status %0d", $time, status);
				failed = 1;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status || code_bits !== e.code_bits ||
						code_len !== e.code_len || out_symbol !== e.out_symbol) begin
					$display("%0t mismatch exp %0d %h %0d %0d got %0d %h %0d %0d", $time,
						e.status, e.code_bits, e.code_len, e.out_symbol,
						status, code_bits, code_len, out_symbol);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	int burst_left = 0;

	task automatic send_item(input logic [1:0] f, input logic [7:0] s,
			input logic [5:0] l, input logic b);
		chc_pkg::item_t it;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(0, 4)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		func <= f;
		symbol <= s;
		length <= l;
		bit_req <= b;
		it = '{func: f, symbol: s, length: l, bit_req: b};
		@(posedge clk);
		while (busy) @(posedge clk);
		predict(it);
	endtask

	task automatic send_code(input logic [7:0] s);
		logic [31:0] c;
		int n;
		if (stale) rebuild_codes();
		n = len_tab[s];
		c = code_tab[s];
		for (int i = n - 1; i >= 0; i--) send_item(chc_pkg::FN_DEC, '0, '0, c[i]);
	endtask

	task automatic test_directed();
		send_item(chc_pkg::FN_ENC, 8'd0, '0, 0);
		send_item(chc_pkg::FN_DEC, '0, '0, 1'b1);
		send_item(chc_pkg::FN_LOAD, 8'd0, 6'd1, 0);
		send_item(chc_pkg::FN_LOAD, 8'd255, 6'd63, 0);
		send_item(chc_pkg::FN_LOAD, 8'd7, 6'd2, 0);
		send_item(chc_pkg::FN_LOAD, 8'd9, 6'd33, 1);
		send_item(FN_NONE, 8'hff, 6'h3f, 1);
		send_item(chc_pkg::FN_ENC, 8'd0, 6'h3f, 1);
		send_item(chc_pkg::FN_ENC, 8'd255, '0, 0);
		send_item(chc_pkg::FN_ENC, 8'd7, '0, 0);
		send_item(chc_pkg::FN_ENC, 8'd9, '0, 0);
		send_item(chc_pkg::FN_ENC, 8'd100, '0, 0);
		send_code(8'd7);
		send_code(8'd255);
		send_code(8'd0);
		send_item(chc_pkg::FN_DEC, '0, '0, 1'b1);
		send_item(chc_pkg::FN_LOAD, 8'd1, 6'd1, 0);
		send_item(chc_pkg::FN_LOAD, 8'd2, 6'd1, 0);
		send_item(chc_pkg::FN_ENC, 8'd2, '0, 0);
		send_item(chc_pkg::FN_ENC, 8'd255, '0, 0);
		for (int i = 0; i < 4; i++) send_item(chc_pkg::FN_DEC, '0, '0, 1'b1);
	endtask

	task automatic test_overflow();
		send_item(chc_pkg::FN_LOAD, 8'd0, 6'd0, 0);
		send_item(chc_pkg::FN_LOAD, 8'd1, 6'd0, 0);
		send_item(chc_pkg::FN_LOAD, 8'd2, 6'd0, 0);
		send_item(chc_pkg::FN_LOAD, 8'd7, 6'd0, 0);
		send_item(chc_pkg::FN_LOAD, 8'd9, 6'd0, 0);
		send_item(chc_pkg::FN_LOAD, 8'd255, 6'd0, 0);
		for (int i = 0; i < 33; i++) send_item(chc_pkg::FN_DEC, '0, '0, i[0]);
	endtask

	task automatic test_random_tables(input int rounds);
		logic [7:0] s;
		for (int r = 0; r < rounds; r++) begin
			for (int i = 0; i < 6; i++)
				send_item(chc_pkg::FN_LOAD, 8'($urandom), 6'($urandom_range(0, 10)),
					1'($urandom));
			if (r % 7 == 0) send_item(chc_pkg::FN_LOAD, 8'($urandom), 6'($urandom), 0);
			for (int i = 0; i < 12; i++) begin
				s = 8'($urandom);
				case ($urandom_range(0, 5))
					0: send_item(chc_pkg::FN_ENC, s, 6'($urandom), 1'($urandom));
					1: send_item(chc_pkg::FN_DEC, s, '0, 1'($urandom));
					2: send_item(FN_NONE, s, 6'($urandom), 1'($urandom));
					default: begin
						if (len_tab[s] != 0) begin
							send_item(chc_pkg::FN_ENC, s, '0, 0);
							send_code(s);
						end else begin
							send_item(chc_pkg::FN_ENC, s, '0, 0);
						end
					end
				endcase
			end
		end
	endtask

	initial begin
		for (int i = 0; i < N_SYM; i++) begin
			len_tab[i] = 0;
			code_tab[i] = 0;
			sym_by_rank[i] = 0;
		end
		for (int i = 0; i <= MAX_LEN; i++) begin
			cnt_at[i] = 0;
			first_code[i] = 0;
			first_idx[i] = 0;
		end
		stale = 1;
		acc_code = 0;
		acc_len = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random_tables(24);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/chc_pkg.sv
rtl/core/chc_front.sv
rtl/core/chc_back.sv
rtl/core/canonical_huffman_codec.sv
bench/tb.sv
